// ===== sv/bloom_filter_insert_query_defines.svh =====
// Assertion macros used by the bloom filter engine (bfiq_back).
`ifndef BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH
`define BLOOM_FILTER_INSERT_QUERY_DEFINES_SVH

`ifndef SYNTH
`define BFIQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bloom filter assertion failed");
`define BFIQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bloom filter assertion failed");
`else
`define BFIQ_ASSERT_IMPL(label, ante, cons)
`define BFIQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/bfiq_pkg.sv =====
// Shared types and constants of the bloom filter.
package bfiq_pkg;

  localparam int BITS_MAX_DEF   = 65536;
  localparam int HASHES_MAX_DEF = 7;
  localparam int NUM_HASH       = 7;

  localparam int BIT_COUNT_W  = 17;
  localparam int HASH_COUNT_W = 3;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT = 1'd1;

  localparam int H_AP   = 0;
  localparam int H_DEK  = 1;
  localparam int H_DJB  = 2;
  localparam int H_SDBM = 3;
  localparam int H_BKDR = 4;
  localparam int H_JS   = 5;
  localparam int H_RS   = 6;

  localparam logic [31:0] AP_INIT  = 32'hAAAAAAAA;
  localparam logic [31:0] DJB_INIT = 32'd5381;
  localparam logic [31:0] JS_INIT  = 32'd1315423911;
  localparam logic [31:0] RS_A     = 32'd378551;
  localparam logic [31:0] RS_B     = 32'd63689;
  localparam logic [31:0] BKDR_SEED = 32'd131;

  typedef struct packed {
    logic                       mode;
    logic [NUM_HASH-1:0][31:0]  h;
  } hash_set_t;

endpackage

// ===== sv/bfiq_if.sv =====
// Valid/ready channel interfaces for key bytes and results.
interface bfiq_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] key_byte;
  logic       last_byte;
  modport source(output valid, mode, key_byte, last_byte, input ready);
  modport sink(input valid, mode, key_byte, last_byte, output ready);
endinterface

interface bfiq_out_if;
  logic valid;
  logic ready;
  logic was_query;
  logic found;
  modport source(output valid, was_query, found, input ready);
  modport sink(input valid, was_query, found, output ready);
endinterface

// ===== sv/bfiq_front.sv =====
// Byte-serial hash front end: runs seven string hashes and hands finished keys on.
module bfiq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  bfiq_in_if.sink            in_ch,
  output logic               push_valid,
  input  logic               push_ready,
  output bfiq_pkg::hash_set_t push_data
);

  logic [bfiq_pkg::NUM_HASH-1:0][31:0] acc_r, acc_nxt;
  logic [31:0] rsm_r, rsm_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] c, h_ap, h_rs, rot;
  logic [63:0] rot_w;
  logic [4:0]  rot_amt;
  logic        accept;

  assign in_ch.ready = en && push_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push_valid  = in_ch.valid && en && in_ch.last_byte;

  always_comb begin
    c    = 32'(in_ch.key_byte);
    h_ap = acc_r[bfiq_pkg::H_AP];
    h_rs = acc_r[bfiq_pkg::H_RS];
    acc_nxt = acc_r;
    if (!cnt_r[0]) begin
      acc_nxt[bfiq_pkg::H_AP] = h_ap ^ ((h_ap << 7) ^ (c * (h_ap >> 3)));
    end else begin
      acc_nxt[bfiq_pkg::H_AP] = h_ap ^ ~((h_ap << 11) + (c ^ (h_ap >> 5)));
    end
    acc_nxt[bfiq_pkg::H_DEK] = ((acc_r[bfiq_pkg::H_DEK] << 5)
                               ^ (acc_r[bfiq_pkg::H_DEK] >> 27)) ^ c;
    acc_nxt[bfiq_pkg::H_DJB] = (acc_r[bfiq_pkg::H_DJB] << 5) + acc_r[bfiq_pkg::H_DJB] + c;
    acc_nxt[bfiq_pkg::H_SDBM] = c + (acc_r[bfiq_pkg::H_SDBM] << 6)
                                + (acc_r[bfiq_pkg::H_SDBM] << 16) - acc_r[bfiq_pkg::H_SDBM];
    acc_nxt[bfiq_pkg::H_BKDR] = acc_r[bfiq_pkg::H_BKDR] * bfiq_pkg::BKDR_SEED + c;
    acc_nxt[bfiq_pkg::H_JS] = acc_r[bfiq_pkg::H_JS]
                              ^ ((acc_r[bfiq_pkg::H_JS] << 5) + c + (acc_r[bfiq_pkg::H_JS] >> 2));
    acc_nxt[bfiq_pkg::H_RS] = h_rs * rsm_r + c;
    rsm_nxt = rsm_r * bfiq_pkg::RS_A;
    cnt_nxt = cnt_r + 32'd1;

    // The DEK length seed is folded in as the byte count rotated by five times itself.
    rot_amt = 5'(cnt_nxt[4:0] * 5'd5);
    rot_w   = {cnt_nxt, cnt_nxt} << rot_amt;
    rot     = rot_w[63:32];

    push_data.mode = in_ch.mode;
    push_data.h    = acc_nxt;
    push_data.h[bfiq_pkg::H_DEK] = acc_nxt[bfiq_pkg::H_DEK] ^ rot;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_ch.last_byte)) begin
      acc_r <= '0;
      acc_r[bfiq_pkg::H_AP]  <= bfiq_pkg::AP_INIT;
      acc_r[bfiq_pkg::H_DJB] <= bfiq_pkg::DJB_INIT;
      acc_r[bfiq_pkg::H_JS]  <= bfiq_pkg::JS_INIT;
      rsm_r <= bfiq_pkg::RS_B;
      cnt_r <= '0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      rsm_r <= rsm_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== sv/bfiq_queue.sv =====
// Two-entry queue of finished hash sets between the front end and the filter engine.
module bfiq_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  bfiq_pkg::hash_set_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output bfiq_pkg::hash_set_t pop_data
);

  bfiq_pkg::hash_set_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== sv/bfiq_back.sv =====
// Filter engine: reduces each hash modulo m bit-serially and probes or sets the bit array.
`include "bloom_filter_insert_query_defines.svh"
module bfiq_back #(
  parameter int BITS_MAX   = bfiq_pkg::BITS_MAX_DEF,
  parameter int HASHES_MAX = bfiq_pkg::HASHES_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                bc_default,
  input  logic [bfiq_pkg::BIT_COUNT_W-1:0]    bit_count,
  input  logic [bfiq_pkg::HASH_COUNT_W-1:0]   hash_count,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  bfiq_pkg::hash_set_t                 pop_data,
  output logic                                busy,
  bfiq_out_if.source                          out_ch
);

  localparam int MW       = $clog2(BITS_MAX + 1);
  localparam int ROWS     = (BITS_MAX + 31) / 32;
  localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(ROWS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [31:0] mem [ROWS];
  logic [31:0] rd_data_r;

  logic [2:0]  state_r, state_nxt;
  bfiq_pkg::hash_set_t set_r;
  logic [31:0] dsh_r, dsh_nxt;
  logic [MW-1:0] rem_r, rem_nxt, m_r, m_nxt;
  logic [2:0]  k_r, k_nxt, hidx_r, hidx_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic        found_r, found_nxt;
  logic [ROW_AW-1:0] clr_row_r, clr_row_nxt;
  logic        out_valid_r, was_query_r, out_found_r;
  logic        out_free, emit;

  logic [MW:0]   trial;
  logic [31:0]   rem32, m32;
  logic [ROW_AW-1:0] row;
  logic [4:0]    bsel;
  logic          mem_we;
  logic [ROW_AW-1:0] mem_wa;
  logic [31:0]   mem_wd;

  assign busy      = (state_r == ST_CLEAR);
  assign pop_ready = (state_r == ST_IDLE);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign emit      = (state_r == ST_DONE) && out_free;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.was_query = was_query_r;
  assign out_ch.found     = out_found_r;

  assign rem32 = 32'(rem_r);
  assign row   = ROW_AW'(rem32 >> 5);
  assign bsel  = rem32[4:0];

  always_comb begin
    // Effective m and k, clamped to their legal ranges.
    if (bc_default) begin
      m32 = 32'(BITS_MAX);
    end else if (bit_count == '0) begin
      m32 = 32'd1;
    end else if (32'(bit_count) > 32'(BITS_MAX)) begin
      m32 = 32'(BITS_MAX);
    end else begin
      m32 = 32'(bit_count);
    end
    if (hash_count == '0) begin
      k_nxt = 3'd1;
    end else if (32'(hash_count) > 32'(HASHES_MAX)) begin
      k_nxt = 3'(HASHES_MAX);
    end else begin
      k_nxt = hash_count;
    end
    m_nxt = MW'(m32);

    trial = {rem_r, dsh_r[31]};

    state_nxt   = state_r;
    dsh_nxt     = dsh_r;
    rem_nxt     = rem_r;
    hidx_nxt    = hidx_r;
    dcnt_nxt    = dcnt_r;
    found_nxt   = found_r;
    clr_row_nxt = clr_row_r;
    mem_we      = 1'b0;
    mem_wa      = row;
    mem_wd      = rd_data_r | (32'd1 << bsel);

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_wa      = clr_row_r;
        mem_wd      = '0;
        clr_row_nxt = clr_row_r + ROW_AW'(1);
        if (clr_row_r == LAST_ROW) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop_valid) begin
          dsh_nxt   = pop_data.h[0];
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          hidx_nxt  = '0;
          found_nxt = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // One restoring step: shift in the next dividend bit, subtract m if it fits.
        if (trial >= {1'b0, m_r}) begin
          rem_nxt = MW'(trial - {1'b0, m_r});
        end else begin
          rem_nxt = MW'(trial);
        end
        dsh_nxt  = dsh_r << 1;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!set_r.mode) begin
          mem_we = 1'b1;
        end else begin
          found_nxt = found_r & rd_data_r[bsel];
        end
        hidx_nxt = hidx_r + 3'd1;
        if (hidx_r + 3'd1 == k_r) begin
          state_nxt = ST_DONE;
        end else begin
          dsh_nxt   = set_r.h[hidx_r + 3'd1];
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[row];
  end

  always_ff @(posedge clk) begin
    dsh_r  <= dsh_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    found_r <= found_nxt;
    if (state_r == ST_IDLE && pop_valid) begin
      set_r <= pop_data;
      m_r   <= m_nxt;
      k_r   <= k_nxt;
    end
    if (emit) begin
      was_query_r <= set_r.mode;
      out_found_r <= set_r.mode & found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_row_r   <= '0;
      hidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_row_r <= clr_row_nxt;
      hidx_r    <= hidx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `BFIQ_ASSERT_IMPL(a_index_in_range, state_r == ST_READ, rem_r < m_r)
  `BFIQ_ASSERT_IMPL(a_hash_below_k, state_r == ST_DIV, hidx_r < k_r)
  `BFIQ_ASSERT_IMPL(a_insert_not_found, out_valid_r && !was_query_r, !out_found_r)
  `BFIQ_ASSERT_NEXT(a_clear_ends_idle, state_r == ST_CLEAR && clr_row_r == LAST_ROW, state_r == ST_IDLE)

endmodule

// ===== sv/bloom_filter_insert_query.sv =====
// Bloom filter top level. Key bytes are taken one per cycle while the queue has room,
// each one updating seven string hashes (AP, DEK, DJB, SDBM, BKDR, JS, RS) in the front
// end. A last byte hands the finished hash set through a two-entry queue to the filter
// engine, which reduces each of the first k hashes modulo m with a bit-serial restoring
// divider and then reads, and on insert rewrites, one 32-bit row of the bit array. The
// front end keeps hashing the next keys while the engine works, until the queue is full.
// After reset the bit array is cleared row by row, ceil(BITS_MAX/32) rows (2048 at the
// default), during which no byte is taken. Configuration is sampled when a key enters
// the engine.
module bloom_filter_insert_query #(
  parameter int BITS_MAX   = bfiq_pkg::BITS_MAX_DEF,
  parameter int HASHES_MAX = bfiq_pkg::HASHES_MAX_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bfiq_in_if.sink                         in_ch,
  bfiq_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bfiq_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bfiq_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [bfiq_pkg::BIT_COUNT_W-1:0]  bit_count_r;
  logic [bfiq_pkg::HASH_COUNT_W-1:0] hash_count_r;
  logic                              bc_default_r;
  logic                              busy, push_valid, push_ready, pop_valid, pop_ready;
  bfiq_pkg::hash_set_t               push_data, pop_data;

  // Until bit_count is first written, the full BITS_MAX is in use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= '0;
      hash_count_r <= bfiq_pkg::HASH_COUNT_W'(HASHES_MAX);
      bc_default_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bfiq_pkg::CFG_BIT_COUNT: begin
          bit_count_r  <= cfg_data[bfiq_pkg::BIT_COUNT_W-1:0];
          bc_default_r <= 1'b0;
        end
        bfiq_pkg::CFG_HASH_COUNT: begin
          hash_count_r <= cfg_data[bfiq_pkg::HASH_COUNT_W-1:0];
        end
        default: begin
          bc_default_r <= bc_default_r;
        end
      endcase
    end
  end

  bfiq_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (!busy),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bfiq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bfiq_back #(
    .BITS_MAX   (BITS_MAX),
    .HASHES_MAX (HASHES_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bc_default (bc_default_r),
    .bit_count  (bit_count_r),
    .hash_count (hash_count_r),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .busy       (busy),
    .out_ch     (out_ch)
  );

endmodule
